### hw/rtl/dssu_pkg.sv
package dssu_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int VALUE_BITS  = 31;
    // decimal digits needed to hold any VALUE_BITS-bit value
    localparam int BCD_DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int POS_W       = 4;
    localparam int SEG_W       = 8;
    localparam int IDX_W       = $clog2(DIGIT_COUNT);
    localparam int CNT_W       = $clog2(VALUE_BITS);

    localparam int DP_POS_LO = 4;
    localparam int DP_POS_HI = 7;
    localparam logic [SEG_W-1:0] DP_MASK = 8'h80;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_DONE = 3'b100
    } conv_state_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h7E;
            4'd1:    pat = 8'h30;
            4'd2:    pat = 8'h6D;
            4'd3:    pat = 8'h79;
            4'd4:    pat = 8'h33;
            4'd5:    pat = 8'h5B;
            4'd6:    pat = 8'h5F;
            4'd7:    pat = 8'h70;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h7B;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

### hw/rtl/dssu_cell.sv
// One BCD digit of the shift-add-3 converter.
module dssu_cell (
    input  logic                  aclk,
    input  dssu_pkg::cell_ctrl_t  ctrl,
    input  logic                  carry_in,
    input  logic                  nz_in,
    output logic                  carry_out,
    output logic                  nz_out,
    output logic [3:0]            digit_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    always_comb begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        carry_out = adj[3];
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.shift) begin
            digit_next = {adj[2:0], carry_in};
        end else begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    // lit when this digit or any higher one is nonzero
    assign nz_out    = nz_in | (digit_reg != 4'd0);
    assign digit_out = digit_reg;

endmodule

### hw/rtl/dssu_writer.sv
// Holds one update's segment patterns and hands them out as digit writes.
module dssu_writer (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      load,
    input  logic [dssu_pkg::DIGIT_COUNT-1:0][dssu_pkg::SEG_W-1:0] load_pat,
    output logic                                      load_ready,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [dssu_pkg::POS_W-1:0]                m_digit_position,
    output logic [dssu_pkg::SEG_W-1:0]                m_segment_pattern,
    output logic                                      m_last_write
);

    logic [dssu_pkg::DIGIT_COUNT-1:0][dssu_pkg::SEG_W-1:0] pat_reg;
    logic [dssu_pkg::DIGIT_COUNT-1:0][dssu_pkg::SEG_W-1:0] pat_next;
    logic                                                  busy_reg;
    logic                                                  busy_next;
    logic [dssu_pkg::IDX_W-1:0]                            idx_reg;
    logic [dssu_pkg::IDX_W-1:0]                            idx_next;
    logic                                                  last;

    assign last       = (idx_reg == dssu_pkg::IDX_W'(dssu_pkg::DIGIT_COUNT - 1));
    assign load_ready = !busy_reg || (m_ready && last);

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        pat_next  = pat_reg;
        if (busy_reg && m_ready) begin
            idx_next = idx_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
            end
        end
        if (load && load_ready) begin
            busy_next = 1'b1;
            idx_next  = '0;
            pat_next  = load_pat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        pat_reg <= pat_next;
    end

    assign m_valid           = busy_reg;
    assign m_digit_position  = dssu_pkg::POS_W'(idx_reg) + dssu_pkg::POS_W'(1);
    assign m_segment_pattern = pat_reg[idx_reg];
    assign m_last_write      = last;

endmodule

### hw/rtl/decimal_seven_segment_update.sv
// Decimal seven-segment display updater.
// Input channel s_*: one binary value per item on s_display_value. A value
// equal to the one last shown is accepted and produces nothing.
// A new value is stored, then converted to BCD by a row of digit cells, one
// shift-add-3 step per input bit.
// Result channel m_*: eight digit writes per new value, digit 1 first, the
// last flagged by m_last_write. Higher digits above the number are blank,
// decimal points sit on digits 4 and 7 when those digits are lit.
// A new value is taken only once the bit-serial conversion of the one before
// is finished; writes of one value go out while the next one converts.
// If the receiver stalls, the finished conversion waits in the cells and
// the input stalls until the write buffer can take it.
// Reset clears the shown value to zero (so a zero right after reset emits
// nothing) and drops any pending writes.
module decimal_seven_segment_update (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dssu_pkg::VALUE_BITS-1:0]     s_display_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dssu_pkg::POS_W-1:0]          m_digit_position,
    output logic [dssu_pkg::SEG_W-1:0]          m_segment_pattern,
    output logic                                m_last_write
);

    localparam int NB = dssu_pkg::BCD_DIGITS;

    dssu_pkg::conv_state_t              state_reg;
    dssu_pkg::conv_state_t              state_next;
    logic [dssu_pkg::VALUE_BITS-1:0]    shown_reg;
    logic [dssu_pkg::VALUE_BITS-1:0]    shown_next;
    logic [dssu_pkg::VALUE_BITS-1:0]    val_reg;
    logic [dssu_pkg::VALUE_BITS-1:0]    val_next;
    logic [dssu_pkg::CNT_W-1:0]         cnt_reg;
    logic [dssu_pkg::CNT_W-1:0]         cnt_next;

    dssu_pkg::cell_ctrl_t               ctrl;
    logic                               accept;
    logic                               start;
    logic                               load;
    logic                               load_ready;
    logic [NB:0]                        carry;
    logic [NB:0]                        nz;
    logic [NB-1:0][3:0]                 digit;
    logic [dssu_pkg::DIGIT_COUNT-1:0][dssu_pkg::SEG_W-1:0] load_pat;

    assign load    = (state_reg == dssu_pkg::ST_DONE);
    assign s_ready = (state_reg == dssu_pkg::ST_IDLE) || (load && load_ready);
    assign accept  = s_valid && s_ready;
    assign start   = accept && (s_display_value != shown_reg);

    always_comb begin
        state_next = state_reg;
        shown_next = shown_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        unique case (state_reg)
            dssu_pkg::ST_IDLE: ;
            dssu_pkg::ST_CONV: begin
                ctrl.shift = 1'b1;
                val_next   = {val_reg[dssu_pkg::VALUE_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == dssu_pkg::CNT_W'(dssu_pkg::VALUE_BITS - 1)) begin
                    state_next = dssu_pkg::ST_DONE;
                end
            end
            dssu_pkg::ST_DONE: begin
                if (load_ready) begin
                    state_next = dssu_pkg::ST_IDLE;
                end
            end
            default: state_next = dssu_pkg::ST_IDLE;
        endcase
        if (start) begin
            ctrl.clear = 1'b1;
            ctrl.shift = 1'b0;
            shown_next = s_display_value;
            val_next   = s_display_value;
            cnt_next   = '0;
            state_next = dssu_pkg::ST_CONV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dssu_pkg::ST_IDLE;
            shown_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            shown_reg <= shown_next;
            cnt_reg   <= cnt_next;
        end
        val_reg <= val_next;
    end

    // bits enter the least significant cell, carries ripple upward
    assign carry[0] = val_reg[dssu_pkg::VALUE_BITS-1];
    assign nz[NB]   = 1'b0;

    for (genvar i = 0; i < NB; i++) begin : g_cell
        dssu_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .carry_in  (carry[i]),
            .nz_in     (nz[i+1]),
            .carry_out (carry[i+1]),
            .nz_out    (nz[i]),
            .digit_out (digit[i])
        );
    end

    for (genvar p = 0; p < dssu_pkg::DIGIT_COUNT; p++) begin : g_pat
        localparam logic HAS_DP = (p + 1 == dssu_pkg::DP_POS_LO) ||
                                  (p + 1 == dssu_pkg::DP_POS_HI);
        always_comb begin
            if (nz[p]) begin
                load_pat[p] = dssu_pkg::seg_pattern(digit[p]) |
                              (HAS_DP ? dssu_pkg::DP_MASK : '0);
            end else begin
                load_pat[p] = '0;
            end
        end
    end

    dssu_writer u_writer (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (load),
        .load_pat          (load_pat),
        .load_ready        (load_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_digit_position  (m_digit_position),
        .m_segment_pattern (m_segment_pattern),
        .m_last_write      (m_last_write)
    );

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [dssu_pkg::POS_W-1:0] pos;
        logic [dssu_pkg::SEG_W-1:0] seg;
        logic                       last;
    } digit_write_t;

    // segments a..g for decimal 0..9
    localparam logic [dssu_pkg::SEG_W-1:0] DIGIT_GLYPHS [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    localparam int RANDOM_UPDATES = 200;
    localparam int PHASE1_START   = 110;
    localparam int PHASE2_START   = 220;
    localparam int HOLD_AT        = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 64;
    localparam int CYCLE_LIMIT    = 200000;

    logic                            aclk;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [dssu_pkg::VALUE_BITS-1:0] s_display_value = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [dssu_pkg::POS_W-1:0]      m_digit_position;
    logic [dssu_pkg::SEG_W-1:0]      m_segment_pattern;
    logic                            m_last_write;

    logic [dssu_pkg::VALUE_BITS-1:0] display_q[$];
    digit_write_t                    write_q[$];
    logic [dssu_pkg::VALUE_BITS-1:0] last_shown = '0;
    int                              accepted = 0;
    int                              errors = 0;
    int                              cycles = 0;
    int                              hold_left = 0;
    bit                              hold_done = 1'b0;

    decimal_seven_segment_update dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_display_value   (s_display_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_digit_position  (m_digit_position),
        .m_segment_pattern (m_segment_pattern),
        .m_last_write      (m_last_write)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int sender_idle_pct();
        if (accepted < PHASE1_START) return 30;
        if (accepted < PHASE2_START) return 50;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted < PHASE1_START) return 50;
        if (accepted < PHASE2_START) return 30;
        return 0;
    endfunction

    // new value: store it and queue the eight digit writes it causes
    task automatic predict_update(input logic [dssu_pkg::VALUE_BITS-1:0] value);
        int unsigned  rest;
        digit_write_t w;
        if (value != last_shown) begin
            last_shown = value;
            rest = 32'(value);
            for (int pos = 1; pos <= dssu_pkg::DIGIT_COUNT; pos++) begin
                w.seg = '0;
                if (rest != 0) begin
                    w.seg = DIGIT_GLYPHS[rest % 10];
                    if (pos == dssu_pkg::DP_POS_LO || pos == dssu_pkg::DP_POS_HI)
                        w.seg = w.seg | dssu_pkg::DP_MASK;
                    rest = rest / 10;
                end
                w.pos  = pos[dssu_pkg::POS_W-1:0];
                w.last = (pos == dssu_pkg::DIGIT_COUNT);
                write_q.push_back(w);
            end
        end
    endtask

    function automatic logic [dssu_pkg::VALUE_BITS-1:0] random_value(
        logic [dssu_pkg::VALUE_BITS-1:0] prev
    );
        int unsigned r;
        int unsigned k;
        int unsigned v;
        r = $urandom_range(0, 99);
        v = 0;
        if (r < 15) begin
            v = 32'(prev);
        end else if (r < 30) begin
            v = $urandom_range(0, 999);
        end else if (r < 55) begin
            k = $urandom_range(1, dssu_pkg::DIGIT_COUNT);
            v = $urandom_range(10 ** (k - 1), 10 ** k - 1);
        end else if (r < 70) begin
            v = $urandom_range(100000000, 2147483647);
        end else if (r < 82) begin
            // decimal numbers with many inner zeros
            for (int i = 0; i < dssu_pkg::DIGIT_COUNT; i++)
                v = v * 10 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9));
        end else begin
            v = $urandom();
        end
        return v[dssu_pkg::VALUE_BITS-1:0];
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_update(s_display_value);
                accepted <= accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (display_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    s_valid         <= 1'b1;
                    s_display_value <= display_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off to back up the block
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && accepted >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // result checker
    always @(posedge aclk) begin
        digit_write_t w;
        if (aresetn && m_valid && m_ready) begin
            if (write_q.size() == 0) begin
                $error("unexpected digit write: position %0d pattern %h last %b",
                       m_digit_position, m_segment_pattern, m_last_write);
                errors++;
            end else begin
                w = write_q.pop_front();
                if (m_digit_position !== w.pos) begin
                    $error("digit_position: expected %0d, got %0d", w.pos, m_digit_position);
                    errors++;
                end
                if (m_segment_pattern !== w.seg) begin
                    $error("segment_pattern: expected %h, got %h", w.seg, m_segment_pattern);
                    errors++;
                end
                if (m_last_write !== w.last) begin
                    $error("last_write: expected %b, got %b", w.last, m_last_write);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [dssu_pkg::VALUE_BITS-1:0] prev;
        logic [dssu_pkg::VALUE_BITS-1:0] v;
        int                              updates;

        // zero right after reset changes nothing
        display_q.push_back(31'd0);
        display_q.push_back(31'd1);
        display_q.push_back(31'd9);
        display_q.push_back(31'd10);
        display_q.push_back(31'd99);
        display_q.push_back(31'd1000);
        display_q.push_back(31'd1000000);
        display_q.push_back(31'd10203040);
        display_q.push_back(31'd1234567);
        display_q.push_back(31'd9999999);
        display_q.push_back(31'd12345678);
        display_q.push_back(31'd99999999);
        // too wide: only the low digits show, here all zeros
        display_q.push_back(31'd100000000);
        display_q.push_back(31'd2147483647);
        display_q.push_back(31'd2147483647);
        display_q.push_back(31'h2AAAAAAA);
        display_q.push_back(31'h55555555);
        display_q.push_back(31'd1073741824);
        display_q.push_back(31'd5);
        display_q.push_back(31'd5);
        // zero blanks every digit
        display_q.push_back(31'd0);
        display_q.push_back(31'd7654321);
        display_q.push_back(31'd0);
        display_q.push_back(31'd8080808);

        prev    = 31'd8080808;
        updates = 0;
        while (updates < RANDOM_UPDATES) begin
            v = random_value(prev);
            if (v != prev) updates++;
            display_q.push_back(v);
            prev = v;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (display_q.size() != 0 || s_valid || write_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
